### rtl/k_permutation_enumerator_assert.svh
// Assertion macros for the k-permutation enumerator.
// Included by the top level; no other dependencies.
`ifndef K_PERMUTATION_ENUMERATOR_ASSERT_SVH
`define K_PERMUTATION_ENUMERATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KPE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("kpe assertion failed");
`define KPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("kpe assertion failed");
`else
`define KPE_ASSERT_SAME(label, clk, rst, ante, cons)
`define KPE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/kpe_pkg.sv
// Shared constants and types for the k-permutation enumerator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package kpe_pkg;

   localparam int MAX_SLOTS    = 4;
   localparam int MAX_CHANNELS = 8;

   // Widths fixed by the register and field definitions.
   localparam int K_W     = 3;
   localparam int N_W     = 4;
   localparam int FIELD_W = 3;
   localparam int TOTAL_W = 11;
   localparam int NUM_FIELDS = 4;

   // A digit is wide enough for any channel index and for the slot field.
   localparam int DIGIT_W = ($clog2(MAX_CHANNELS) > FIELD_W) ? $clog2(MAX_CHANNELS) : FIELD_W;
   localparam int CMP_W   = (DIGIT_W + 1 > N_W) ? DIGIT_W + 1 : N_W;
   localparam int PROD_W  = TOTAL_W + N_W;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   localparam logic [K_W-1:0] K_RESET = 3'd4;
   localparam logic [N_W-1:0] N_RESET = 4'd8;

   // Register file: one bit of the byte address selects the register.
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_PERM_LENGTH   = 1'b0;
   localparam logic REG_CHANNEL_COUNT = 1'b1;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [MAX_SLOTS-1:0][DIGIT_W-1:0] slot_vec_type;

   typedef struct packed {
      logic clear;
      logic seed;
      logic step;
   } slot_cmd_type;

   typedef struct packed {
      logic roll;
      logic distinct;
   } slot_status_type;

endpackage

`default_nettype wire

### rtl/kpe_csr.sv
// Configuration registers (tuple length k and channel count n) behind an APB port.
// Depends on kpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpe_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [kpe_pkg::ADDR_W-1:0]  csr_paddr,
   input  wire logic [kpe_pkg::DATA_W-1:0]  csr_pwdata,
   output logic      [kpe_pkg::DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output logic      [kpe_pkg::K_W-1:0]     perm_length,
   output logic      [kpe_pkg::N_W-1:0]     channel_count
);

   logic [kpe_pkg::K_W-1:0] k_ff;
   logic [kpe_pkg::K_W-1:0] k_in;
   logic [kpe_pkg::N_W-1:0] n_ff;
   logic [kpe_pkg::N_W-1:0] n_in;
   logic                    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      k_in = k_ff;
      n_in = n_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            kpe_pkg::REG_PERM_LENGTH:   k_in = csr_pwdata[kpe_pkg::K_W-1:0];
            kpe_pkg::REG_CHANNEL_COUNT: n_in = csr_pwdata[kpe_pkg::N_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         kpe_pkg::REG_PERM_LENGTH:   csr_prdata = kpe_pkg::DATA_W'(k_ff);
         kpe_pkg::REG_CHANNEL_COUNT: csr_prdata = kpe_pkg::DATA_W'(n_ff);
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= kpe_pkg::K_RESET;
         n_ff <= kpe_pkg::N_RESET;
      end else begin
         k_ff <= k_in;
         n_ff <= n_in;
      end
   end

   assign perm_length   = k_ff;
   assign channel_count = n_ff;

endmodule

`default_nettype wire

### rtl/kpe_total.sv
// Iterative product unit for the permutation count n*(n-1)*...*(n-k+1).
// One small multiply per cycle, saturating; depends on kpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpe_total (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         cfg_ok,
   input  wire logic [kpe_pkg::K_W-1:0]      perm_length,
   input  wire logic [kpe_pkg::N_W-1:0]      channel_count,
   output logic                              busy,
   output logic      [kpe_pkg::TOTAL_W-1:0]  total_count
);

   logic                         busy_ff;
   logic                         busy_in;
   logic                         ok_ff;
   logic                         ok_in;
   logic [kpe_pkg::K_W-1:0]      idx_ff;
   logic [kpe_pkg::K_W-1:0]      idx_in;
   logic [kpe_pkg::K_W-1:0]      idx_next;
   logic [kpe_pkg::TOTAL_W-1:0]  acc_ff;
   logic [kpe_pkg::TOTAL_W-1:0]  acc_in;
   logic [kpe_pkg::N_W-1:0]      factor;
   logic [kpe_pkg::PROD_W-1:0]   prod;

   // The factor never goes negative: a valid setup has k <= n.
   assign factor   = channel_count - kpe_pkg::N_W'(idx_ff);
   assign prod     = kpe_pkg::PROD_W'(acc_ff) * kpe_pkg::PROD_W'(factor);
   assign idx_next = idx_ff + kpe_pkg::K_W'(1);

   always_comb begin
      busy_in = busy_ff;
      ok_in   = ok_ff;
      idx_in  = idx_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = cfg_ok;
         ok_in   = cfg_ok;
         idx_in  = '0;
         acc_in  = kpe_pkg::TOTAL_W'(1);
      end else if (busy_ff) begin
         acc_in  = (prod > kpe_pkg::PROD_W'(kpe_pkg::TOTAL_MAX)) ? kpe_pkg::TOTAL_MAX
                                                                : prod[kpe_pkg::TOTAL_W-1:0];
         idx_in  = idx_next;
         busy_in = (idx_next != perm_length);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ok_ff   <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         ok_ff   <= ok_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      acc_ff <= acc_in;
   end

   assign busy        = busy_ff;
   assign total_count = ok_ff ? acc_ff : '0;

endmodule

`default_nettype wire

### rtl/kpe_slots.sv
// Slot registers and the shared step unit: one base-n increment with a
// repeated-index check per cycle. Depends on kpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kpe_slots (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire kpe_pkg::slot_cmd_type     cmd,
   input  wire logic [kpe_pkg::K_W-1:0]   perm_length,
   input  wire logic [kpe_pkg::N_W-1:0]   channel_count,
   output kpe_pkg::slot_vec_type          slots,
   output kpe_pkg::slot_status_type       status
);

   kpe_pkg::slot_vec_type slot_ff;
   kpe_pkg::slot_vec_type slot_in;
   kpe_pkg::slot_vec_type step_vec;
   kpe_pkg::slot_vec_type seed_vec;
   logic                  carry;
   logic                  no_repeat;

   // Increment with the last active slot as least significant digit. A digit
   // at or above n (left over from a larger n) overflows to zero and carries.
   always_comb begin
      logic [kpe_pkg::DIGIT_W:0] v;
      step_vec = slot_ff;
      carry    = 1'b1;
      for (int i = kpe_pkg::MAX_SLOTS - 1; i >= 0; i--) begin
         v = {1'b0, slot_ff[i]} + (kpe_pkg::DIGIT_W + 1)'(1);
         if (i < int'(perm_length) && carry) begin
            if (kpe_pkg::CMP_W'(v) < kpe_pkg::CMP_W'(channel_count)) begin
               step_vec[i] = v[kpe_pkg::DIGIT_W-1:0];
               carry       = 1'b0;
            end else begin
               step_vec[i] = '0;
            end
         end
      end
   end

   always_comb begin
      no_repeat = 1'b1;
      for (int a = 0; a < kpe_pkg::MAX_SLOTS; a++) begin
         for (int b = 0; b < kpe_pkg::MAX_SLOTS; b++) begin
            if (a < b && b < int'(perm_length) && step_vec[a] == step_vec[b]) begin
               no_repeat = 1'b0;
            end
         end
      end
   end

   always_comb begin
      seed_vec = slot_ff;
      for (int i = 0; i < kpe_pkg::MAX_SLOTS; i++) begin
         if (i < int'(perm_length)) begin
            seed_vec[i] = kpe_pkg::DIGIT_W'(i);
         end
      end
   end

   always_comb begin
      if (cmd.clear) begin
         slot_in = '0;
      end else if (cmd.seed) begin
         slot_in = seed_vec;
      end else if (cmd.step) begin
         slot_in = step_vec;
      end else begin
         slot_in = slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
      end else begin
         slot_ff <= slot_in;
      end
   end

   assign slots           = slot_ff;
   assign status.roll     = carry;
   assign status.distinct = no_repeat;

endmodule

`default_nettype wire

### rtl/k_permutation_enumerator.sv
// Lexicographic k-permutation enumerator. Each request word returns the next
// tuple of k distinct channel indices out of n, plus the count n!/(n-k)!; a
// request after the last tuple, or with an invalid setup, gets no tuple.
// A request first passes the count unit, which does one multiply per factor,
// then the step unit, which tries one tuple per cycle until a tuple without
// repeats (or a rollover) appears. The first request after reset or restart
// seeds 0..k-1 instead; an invalid setup skips the multiplies and the step
// unit. The result word then waits until the output register is free.
// The block takes one request at a time; a finished result word may wait in
// the output register while the next request is accepted and worked on.
// Depends on kpe_pkg, kpe_csr, kpe_total, kpe_slots and the assertion header.
`timescale 1ns / 1ps
`default_nettype none

`include "k_permutation_enumerator_assert.svh"

module k_permutation_enumerator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_restart,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_produced,
   output logic      [kpe_pkg::FIELD_W-1:0]     rsp_slot_first,
   output logic      [kpe_pkg::FIELD_W-1:0]     rsp_slot_second,
   output logic      [kpe_pkg::FIELD_W-1:0]     rsp_slot_third,
   output logic      [kpe_pkg::FIELD_W-1:0]     rsp_slot_fourth,
   output logic      [kpe_pkg::TOTAL_W-1:0]     rsp_total_count,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [kpe_pkg::ADDR_W-1:0]      csr_paddr,
   input  wire logic [kpe_pkg::DATA_W-1:0]      csr_pwdata,
   output logic      [kpe_pkg::DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_TOTAL = 2'd1;
   localparam logic [1:0] S_WORK  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [kpe_pkg::K_W-1:0]      perm_length;
   logic [kpe_pkg::N_W-1:0]      channel_count;
   logic                         cfg_ok;
   logic                         accept;
   logic                         total_busy;
   logic [kpe_pkg::TOTAL_W-1:0]  total_count;
   kpe_pkg::slot_cmd_type        cmd;
   kpe_pkg::slot_vec_type        slots;
   kpe_pkg::slot_status_type     status;
   logic                         load_out;
   logic                         rsp_slots_zero;

   logic [1:0]                   state_ff;
   logic [1:0]                   state_in;
   logic                         started_ff;
   logic                         started_in;
   logic                         cfg_ok_ff;
   logic                         cfg_ok_in;
   logic                         ok_ff;
   logic                         ok_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         produced_ff;
   logic [kpe_pkg::TOTAL_W-1:0]  total_ff;
   logic [kpe_pkg::NUM_FIELDS-1:0][kpe_pkg::FIELD_W-1:0] field_vec;
   logic [kpe_pkg::NUM_FIELDS-1:0][kpe_pkg::FIELD_W-1:0] field_ff;

   kpe_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .perm_length   (perm_length),
      .channel_count (channel_count)
   );

   kpe_total u_total (
      .clock         (clock),
      .reset         (reset),
      .start         (accept),
      .cfg_ok        (cfg_ok),
      .perm_length   (perm_length),
      .channel_count (channel_count),
      .busy          (total_busy),
      .total_count   (total_count)
   );

   kpe_slots u_slots (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .perm_length   (perm_length),
      .channel_count (channel_count),
      .slots         (slots),
      .status        (status)
   );

   assign cfg_ok = (perm_length != '0)
                && (int'(perm_length) <= int'(channel_count))
                && (int'(perm_length) <= kpe_pkg::MAX_SLOTS)
                && (int'(channel_count) <= kpe_pkg::MAX_CHANNELS);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign cmd.clear = accept && req_restart;
   assign cmd.seed  = (state_ff == S_WORK) && cfg_ok_ff && !started_ff;
   assign cmd.step  = (state_ff == S_WORK) && cfg_ok_ff && started_ff;

   // Slot fields: zero for positions at or past k and for a word without a tuple.
   for (genvar p = 0; p < kpe_pkg::NUM_FIELDS; p++) begin : g_field
      if (p < kpe_pkg::MAX_SLOTS) begin : g_live
         assign field_vec[p] = (ok_ff && p < int'(perm_length))
                             ? slots[p][kpe_pkg::FIELD_W-1:0] : '0;
      end else begin : g_absent
         assign field_vec[p] = '0;
      end
   end

   always_comb begin
      state_in   = state_ff;
      started_in = started_ff;
      cfg_ok_in  = cfg_ok_ff;
      ok_in      = ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cfg_ok_in = cfg_ok;
               if (req_restart) begin
                  started_in = 1'b0;
               end
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            if (!total_busy) begin
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            if (!cfg_ok_ff) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else if (!started_ff) begin
               started_in = 1'b1;
               ok_in      = 1'b1;
               state_in   = S_DONE;
            end else if (status.roll) begin
               ok_in    = 1'b0;
               state_in = S_DONE;
            end else if (status.distinct) begin
               ok_in    = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         started_ff   <= 1'b0;
         cfg_ok_ff    <= 1'b0;
         ok_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         cfg_ok_ff    <= cfg_ok_in;
         ok_ff        <= ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         produced_ff <= ok_ff;
         field_ff    <= field_vec;
         total_ff    <= total_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_produced    = produced_ff;
   assign rsp_slot_first  = field_ff[0];
   assign rsp_slot_second = field_ff[1];
   assign rsp_slot_third  = field_ff[2];
   assign rsp_slot_fourth = field_ff[3];
   assign rsp_total_count = total_ff;

   assign rsp_slots_zero = (rsp_slot_first == '0) && (rsp_slot_second == '0)
                        && (rsp_slot_third == '0) && (rsp_slot_fourth == '0);

   // A word that carries a tuple always comes with a nonzero count.
   `KPE_ASSERT_SAME(a_count_with_tuple, clock, reset, rsp_valid && rsp_produced, rsp_total_count != '0)

   // A word without a tuple carries all slot fields cleared.
   `KPE_ASSERT_SAME(a_empty_slots, clock, reset, rsp_valid && !rsp_produced, rsp_slots_zero)

   // Once a request is taken, the block is busy on the next cycle.
   `KPE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule

`default_nettype wire
